/* hw/rtl/dlh_pkg.sv */
// Shared types, codes and field layout for the datagram link handshake engine.
// Used by dlh_step, datagram_link_handshake and dlh_checker.
package dlh_pkg;

	// stream payload widths; the data widths are padded to whole bytes
	localparam int IN_USER_W  = 3;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 40;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// header constants
	localparam logic [7:0]  SIGN_BYTE    = 8'h99;
	localparam logic [7:0]  VERSION_BYTE = 8'h10;
	localparam logic [13:0] HEADER_BYTES = 14'd16;

	localparam logic [15:0] F_SYN = 16'h0001;
	localparam logic [15:0] F_FIN = 16'h0002;
	localparam logic [15:0] F_ACK = 16'h0008;

	// pending job bits
	localparam int J_SYN     = 0;
	localparam int J_ACK_SYN = 1;
	localparam int J_FIN     = 2;
	localparam int J_ACK_FIN = 3;

	// transmitted flag sets
	localparam logic [3:0] TX_SYN     = 4'h1;
	localparam logic [3:0] TX_SYN_ACK = 4'h9;
	localparam logic [3:0] TX_FIN     = 4'h2;
	localparam logic [3:0] TX_FIN_ACK = 4'hA;
	localparam logic [3:0] TX_NONE    = 4'h0;

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE      = 1'b1;
	localparam logic [7:0] KEEPALIVE_RST = 8'd30;
	localparam logic [7:0] IDLE_RST      = 8'd20;

	typedef enum logic [2:0] {
		CMD_RX       = 3'd0,
		CMD_TX       = 3'd1,
		CMD_CONNECT  = 3'd2,
		CMD_ACCEPT   = 3'd3,
		CMD_SHUTDOWN = 3'd4,
		CMD_TICK     = 3'd5,
		CMD_ERROR    = 3'd6
	} cmd_t;

	localparam logic [2:0] ST_OK                = 3'd0;
	localparam logic [2:0] ST_ALREADY_STARTED   = 3'd1;
	localparam logic [2:0] ST_ALREADY_CONNECTED = 3'd2;
	localparam logic [2:0] ST_NOT_CONNECTED     = 3'd3;
	localparam logic [2:0] ST_BROKEN_PIPE       = 3'd4;

	localparam logic [1:0] SE_NONE    = 2'd0;
	localparam logic [1:0] SE_ABORTED = 2'd1;
	localparam logic [1:0] SE_RESET   = 2'd2;

	localparam logic [1:0] NT_NONE   = 2'd0;
	localparam logic [1:0] NT_DONE   = 2'd1;
	localparam logic [1:0] NT_FAILED = 2'd2;

	localparam logic [7:0] SEC_MAX = 8'hFF;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  rx_sign;
		logic [7:0]  rx_version;
		logic [13:0] rx_size;
		logic [31:0] rx_pin;
		logic [15:0] rx_flags;
	} item_t;

	typedef struct packed {
		logic [7:0] keepalive_timeout_s;
		logic [7:0] idle_interval_s;
	} cfg_t;

	typedef struct packed {
		logic        alive;
		logic        linked;
		logic [15:0] local_pin;
		logic [31:0] remote_pin;
		logic [3:0]  jobs;
		logic        conn_wait;
		logic        shut_wait;
		logic [15:0] pin_ctr;
		logic [7:0]  sec_rx;
		logic        rx_seen;
		logic [7:0]  sec_tx;
	} link_state_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        tx_valid;
		logic [3:0]  tx_flags;
		logic [15:0] tx_pin;
		logic        to_streams;
		logic [1:0]  streams_error;
		logic [1:0]  connect_notify;
		logic [1:0]  shutdown_notify;
		logic        linked;
		logic        alive;
	} result_t;

endpackage

/* hw/rtl/datagram_link_handshake.sv */
// Top level of the datagram link handshake engine: input register, step logic,
// result register and configuration registers. Depends on dlh_pkg and dlh_step.
//
//  channel  | direction | handshake               | payload
//  s_axis   | in        | s_axis_tvalid/tready    | tuser command, tdata header fields
//  m_axis   | out       | m_axis_tvalid/tready    | tdata result fields
//  cfg      | in        | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// One item per cycle while the result is not stalled: an item waits in the input register,
// then the step logic updates the link state and the result register in the same edge.
// The result is valid once the result register loads and, with the sink ready,
// is taken at the edge after it.
// Reset (arst_n low) restores the link state and both registers to their defaults.
// A stalled result holds the input register; a further item is taken only when the
// input register empties. cfg_ready is always high.
module datagram_link_handshake (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [2:0] command
	input  logic [dlh_pkg::IN_USER_W-1:0]  s_axis_tuser,
	// [7:0] rx_sign, [15:8] rx_version, [29:16] rx_size, [61:30] rx_pin,
	// [77:62] rx_flags, [79:78] zero
	input  logic [dlh_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [2:0] status, [3] tx_valid, [7:4] tx_flags, [23:8] tx_pin, [24] to_streams,
	// [26:25] streams_error, [28:27] connect_notify, [30:29] shutdown_notify,
	// [31] linked, [32] alive, [39:33] zero
	output logic [dlh_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dlh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dlh_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dlh_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	cfg_t        cfg_q;
	link_state_t state_q;
	link_state_t state_nxt;
	result_t     res;
	result_t     res_q;
	logic        out_valid_q;
	logic        advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.command    <= s_axis_tuser;
			item_s1.rx_sign    <= s_axis_tdata[7:0];
			item_s1.rx_version <= s_axis_tdata[15:8];
			item_s1.rx_size    <= s_axis_tdata[29:16];
			item_s1.rx_pin     <= s_axis_tdata[61:30];
			item_s1.rx_flags   <= s_axis_tdata[77:62];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.keepalive_timeout_s <= KEEPALIVE_RST;
			cfg_q.idle_interval_s     <= IDLE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_KEEPALIVE: cfg_q.keepalive_timeout_s <= cfg_data;
				CFG_IDLE:      cfg_q.idle_interval_s     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dlh_step u_step (
		.item (item_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.alive      <= 1'b1;
			state_q.linked     <= 1'b0;
			state_q.local_pin  <= '0;
			state_q.remote_pin <= '0;
			state_q.jobs       <= '0;
			state_q.conn_wait  <= 1'b0;
			state_q.shut_wait  <= 1'b0;
			state_q.pin_ctr    <= '0;
			state_q.sec_rx     <= '0;
			state_q.rx_seen    <= 1'b0;
			state_q.sec_tx     <= SEC_MAX;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, res_q.alive, res_q.linked, res_q.shutdown_notify,
		res_q.connect_notify, res_q.streams_error, res_q.to_streams, res_q.tx_pin,
		res_q.tx_flags, res_q.tx_valid, res_q.status};

endmodule

/* hw/rtl/dlh_step.sv */
// Next-state and result logic for one item of the link handshake engine.
// Depends on dlh_pkg.
module dlh_step (
	input  dlh_pkg::item_t       item,
	input  dlh_pkg::cfg_t        cfg,
	input  dlh_pkg::link_state_t cur,
	output dlh_pkg::link_state_t nxt,
	output dlh_pkg::result_t     res
);
	import dlh_pkg::*;

	logic        ready;
	logic        hdr_ok;
	logic        match;
	logic        consumed;
	logic        send;
	logic        connecting;
	logic        shutting;
	logic [15:0] pin_inc;
	cmd_t        cmd;

	assign cmd = cmd_t'(item.command);

	always_comb begin
		nxt        = cur;
		res        = '0;
		ready      = cur.alive && (cur.local_pin != 16'd0);
		connecting = cur.alive && cur.conn_wait;
		shutting   = cur.alive && cur.shut_wait;
		hdr_ok     = (item.rx_sign == SIGN_BYTE) && (item.rx_version == VERSION_BYTE)
			&& (item.rx_size >= HEADER_BYTES);
		match      = (cur.remote_pin == 32'd0) || (cur.remote_pin == item.rx_pin);
		consumed   = 1'b1;
		send       = 1'b0;
		pin_inc    = cur.pin_ctr + 16'd1;
		if (pin_inc == 16'd0) begin
			pin_inc = 16'd1;
		end

		unique case (cmd)
			CMD_RX: begin
				if (ready) begin
					if (hdr_ok) begin
						if (match) begin
							nxt.sec_rx  = 8'd0;
							nxt.rx_seen = 1'b1;
						end
						if (((item.rx_flags & F_SYN) != 16'd0) && match) begin
							nxt.remote_pin = item.rx_pin;
							if ((item.rx_flags & F_ACK) != 16'd0) begin
								nxt.linked = 1'b1;
								if (cur.conn_wait) begin
									res.connect_notify = NT_DONE;
									nxt.conn_wait      = 1'b0;
								end
								nxt.jobs[J_SYN] = 1'b0;
							end else begin
								nxt.jobs[J_ACK_SYN] = 1'b1;
							end
						end else if (((item.rx_flags & F_FIN) != 16'd0)
							&& (cur.remote_pin == item.rx_pin)) begin
							nxt.linked = 1'b0;
							if ((item.rx_flags & F_ACK) != 16'd0) begin
								nxt.remote_pin = 32'd0;
								nxt.alive      = 1'b0;
								if (cur.shut_wait) begin
									res.shutdown_notify = NT_DONE;
									nxt.shut_wait       = 1'b0;
								end
								nxt.jobs[J_FIN] = 1'b0;
							end else begin
								nxt.jobs[J_ACK_FIN] = 1'b1;
							end
						end else begin
							consumed = !(cur.linked && (cur.remote_pin != 32'd0)
								&& (cur.remote_pin == item.rx_pin));
						end
					end
					// a bare fin from the peer aborts, checked against the updated pin
					if (consumed) begin
						if ((nxt.remote_pin != 32'd0) && (item.rx_pin == nxt.remote_pin)
							&& (item.rx_flags == F_FIN)) begin
							res.streams_error = SE_ABORTED;
						end
					end else if (nxt.linked) begin
						res.to_streams = 1'b1;
					end
				end
			end
			CMD_TX: begin
				if (ready) begin
					if (cur.rx_seen && (cur.sec_rx >= cfg.keepalive_timeout_s)) begin
						if (cur.conn_wait) begin
							res.connect_notify = NT_FAILED;
							nxt.conn_wait      = 1'b0;
						end
						if (cur.shut_wait) begin
							res.shutdown_notify = NT_FAILED;
							nxt.shut_wait       = 1'b0;
						end
						nxt.alive         = 1'b0;
						nxt.linked        = 1'b0;
						res.streams_error = SE_RESET;
					end else begin
						send = 1'b1;
						priority if (cur.jobs[J_SYN]) begin
							res.tx_flags = TX_SYN;
						end else if (cur.jobs[J_ACK_SYN]) begin
							res.tx_flags          = TX_SYN_ACK;
							nxt.jobs[J_ACK_SYN]   = 1'b0;
							nxt.linked            = 1'b1;
							if (cur.conn_wait) begin
								res.connect_notify = NT_DONE;
								nxt.conn_wait      = 1'b0;
							end
						end else if (cur.jobs[J_FIN]) begin
							res.tx_flags      = TX_FIN;
							nxt.linked        = 1'b0;
							res.streams_error = SE_ABORTED;
						end else if (cur.jobs[J_ACK_FIN]) begin
							res.tx_flags        = TX_FIN_ACK;
							nxt.jobs[J_ACK_FIN] = 1'b0;
							nxt.alive           = 1'b0;
							if (cur.shut_wait) begin
								res.shutdown_notify = NT_DONE;
								nxt.shut_wait       = 1'b0;
							end
						end else begin
							// nothing pending: keepalive once idle long enough
							res.tx_flags = TX_NONE;
							send = (cur.sec_tx >= cfg.idle_interval_s);
						end
						if (send) begin
							nxt.sec_tx   = 8'd0;
							res.tx_valid = 1'b1;
							res.tx_pin   = cur.local_pin;
						end else begin
							res.tx_flags = TX_NONE;
						end
					end
				end
			end
			CMD_CONNECT, CMD_ACCEPT: begin
				if (!cur.alive || cur.linked || connecting) begin
					res.status = connecting ? ST_ALREADY_STARTED
						: (cur.linked ? ST_ALREADY_CONNECTED : ST_BROKEN_PIPE);
				end else begin
					nxt.pin_ctr   = pin_inc;
					nxt.local_pin = pin_inc;
					nxt.conn_wait = 1'b1;
					if (cmd == CMD_CONNECT) begin
						nxt.jobs[J_SYN] = 1'b1;
					end
				end
			end
			CMD_SHUTDOWN: begin
				if (!cur.alive || !cur.linked || shutting) begin
					res.status = shutting ? ST_ALREADY_STARTED
						: (cur.alive ? ST_NOT_CONNECTED : ST_BROKEN_PIPE);
				end else begin
					nxt.shut_wait   = 1'b1;
					nxt.jobs[J_FIN] = 1'b1;
				end
			end
			CMD_TICK: begin
				if (cur.sec_rx != SEC_MAX) begin
					nxt.sec_rx = cur.sec_rx + 8'd1;
				end
				if (cur.sec_tx != SEC_MAX) begin
					nxt.sec_tx = cur.sec_tx + 8'd1;
				end
			end
			CMD_ERROR: begin
				if (cur.conn_wait) begin
					res.connect_notify = NT_FAILED;
					nxt.conn_wait      = 1'b0;
				end
				if (cur.shut_wait) begin
					res.shutdown_notify = NT_FAILED;
					nxt.shut_wait       = 1'b0;
				end
				nxt.alive  = 1'b0;
				nxt.linked = 1'b0;
			end
			default: begin
			end
		endcase
		res.linked = nxt.linked;
		res.alive  = nxt.alive;
	end

endmodule

/* hw/rtl/dlh_checker.sv */
// Port-level checks for datagram_link_handshake, attached by bind.
// Depends on dlh_pkg.
module dlh_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [dlh_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import dlh_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// input side only backs off when a result is stalled
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

	// no header emitted means flags and pin read zero
	a_tx_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[3] |-> m_axis_tdata[23:4] == 20'd0)
		else $error("tx fields set without tx_valid");

	// an emitted header always carries a chosen local pin
	a_tx_pin: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[23:8] != 16'd0)
		else $error("header emitted with zero pin");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] == ST_OK
			|| m_axis_tdata[2:0] == ST_ALREADY_STARTED
			|| m_axis_tdata[2:0] == ST_ALREADY_CONNECTED
			|| m_axis_tdata[2:0] == ST_NOT_CONNECTED
			|| m_axis_tdata[2:0] == ST_BROKEN_PIPE)
		else $error("status code out of range");

endmodule

bind datagram_link_handshake dlh_checker u_dlh_checker (.*);
